>>> rtl/core/bts_pkg.sv
// Shared types and constants of the bilinear texture sampler.
`default_nettype none
package bts_pkg;

	// Item kinds on the mode field
	localparam logic [1:0] MODE_WRITE    = 2'd0;
	localparam logic [1:0] MODE_NEAREST  = 2'd1;
	localparam logic [1:0] MODE_BILINEAR = 2'd2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WRAP_S     = 2'd2;
	localparam logic [1:0] REG_WRAP_T     = 2'd3;

	// Reset values of the registers
	localparam logic [6:0] TEX_SIZE_RST = 7'd64;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;
	localparam int QCW    = 3;

	// Texel word: three Q8.8 channels, red in the top bits
	localparam int CHW   = 16;
	localparam int NCH   = 3;
	localparam int TEXW  = CHW * NCH;

	// Effective texture setup seen by the datapath
	typedef struct packed {
		logic [6:0] width;
		logic [6:0] height;
		logic       wrap_s;
		logic       wrap_t;
	} cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/bts_queue.sv
// Small command queue between the sampler front and back.
`default_nettype none
module bts_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire logic [WIDTH-1:0]         push_data,
	input  wire logic                     pop,
	output logic      [WIDTH-1:0]         head,
	output logic                          empty,
	output logic      [bts_pkg::QCW-1:0]  count
);

	logic [WIDTH-1:0]        slot_q [bts_pkg::QDEPTH];
	logic [bts_pkg::QPW-1:0] wr_ptr_q;
	logic [bts_pkg::QPW-1:0] rd_ptr_q;
	logic [bts_pkg::QCW-1:0] count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule
`default_nettype wire

>>> rtl/core/bts_front.sv
// Sampler front: takes words, scales coordinates, applies wrap, queues commands.
`default_nettype none
module bts_front #(
	parameter int XW = 6,
	parameter int YW = 6,
	parameter int EW = 1 + bts_pkg::TEXW + 2*XW + 2*YW + 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bts_pkg::cfg_t            cfg,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               mode,
	input  wire logic [5:0]               texel_x,
	input  wire logic [5:0]               texel_y,
	input  wire logic [15:0]              in_red,
	input  wire logic [15:0]              in_green,
	input  wire logic [15:0]              in_blue,
	input  wire logic signed [19:0]       u_coord,
	input  wire logic signed [19:0]       v_coord,
	input  wire logic [bts_pkg::QCW-1:0]  q_count,
	output logic                          push,
	output logic [EW-1:0]                 push_data
);

	typedef struct packed {
		logic                     is_wr;
		logic [bts_pkg::TEXW-1:0] data;
		logic [XW-1:0]            x0;
		logic [XW-1:0]            x1;
		logic [YW-1:0]            y0;
		logic [YW-1:0]            y1;
		logic [15:0]              fx;
		logic [15:0]              fy;
	} entry_t;

	typedef struct packed {
		logic [6:0]  p0;
		logic [6:0]  p1;
		logic [15:0] f;
	} axis_t;

	// Floor of the scaled coordinate, its neighbor, wrap and fraction
	function automatic axis_t wrap_axis(logic signed [27:0] full, logic [22:0] frac,
			logic [6:0] n, logic clamp, logic bil);
		logic signed [27:0] s;
		logic signed [23:0] sf;
		logic signed [12:0] i0;
		logic signed [12:0] i1;
		logic signed [12:0] lim;
		logic signed [7:0]  j;
		logic signed [7:0]  j1;
		logic [6:0]         nm1;
		axis_t              r;
		s   = full - (bil ? 28'sd32768 : 28'sd0);
		sf  = $signed({1'b0, frac}) - (bil ? 24'sd32768 : 24'sd0);
		i0  = $signed({s[27], s[27:16]});
		i1  = i0 + 13'sd1;
		j   = $signed(sf[23:16]);
		j1  = j + 8'sd1;
		nm1 = n - 7'd1;
		lim = $signed({6'b0, nm1});
		if (clamp) begin
			r.p0 = (i0 < 13'sd0) ? 7'd0 : ((i0 > lim) ? nm1 : i0[6:0]);
			r.p1 = (i1 < 13'sd0) ? 7'd0 : ((i1 > lim) ? nm1 : i1[6:0]);
		end else begin
			// fractional part of u*n lands one below zero or up to n
			r.p0 = (j < 8'sd0) ? nm1 : j[6:0];
			r.p1 = (j1[6:0] == n) ? 7'd0 : j1[6:0];
		end
		if (!bil) r.p1 = r.p0;
		r.f = bil ? s[15:0] : 16'd0;
		return r;
	endfunction

	logic accept;
	logic v_s1;
	logic [1:0] mode_s1;
	logic signed [27:0] u_full_s1;
	logic signed [27:0] v_full_s1;
	logic [22:0] u_frac_s1;
	logic [22:0] v_frac_s1;
	logic [bts_pkg::TEXW-1:0] wdata_s1;
	logic [5:0] wx_s1;
	logic [5:0] wy_s1;
	logic wok_s1;

	logic v_s2;
	entry_t entry_s2;
	entry_t entry_nx;
	axis_t ax;
	axis_t ay;
	logic bil;
	logic keep;
	logic [3:0] occupancy;

	// Queue room covers the words still in the two front stages
	assign occupancy = 4'(q_count) + 4'(v_s1) + 4'(v_s2);
	assign busy = (occupancy >= 4'(bts_pkg::QDEPTH));
	assign accept = start && !busy;

	// Stage 1: scale coordinates, check write bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode;
			u_full_s1 <= u_coord * $signed({1'b0, cfg.width});
			v_full_s1 <= v_coord * $signed({1'b0, cfg.height});
			u_frac_s1 <= 23'(u_coord[15:0]) * 23'(cfg.width);
			v_frac_s1 <= 23'(v_coord[15:0]) * 23'(cfg.height);
			wdata_s1  <= {in_red, in_green, in_blue};
			wx_s1     <= texel_x;
			wy_s1     <= texel_y;
			wok_s1    <= ({1'b0, texel_x} < cfg.width) && ({1'b0, texel_y} < cfg.height);
		end
	end

	// Stage 2: wrap and build the command
	assign bil = (mode_s1 == bts_pkg::MODE_BILINEAR);
	assign ax  = wrap_axis(u_full_s1, u_frac_s1, cfg.width, cfg.wrap_s, bil);
	assign ay  = wrap_axis(v_full_s1, v_frac_s1, cfg.height, cfg.wrap_t, bil);

	always_comb begin
		entry_nx.is_wr = (mode_s1 == bts_pkg::MODE_WRITE);
		entry_nx.data  = wdata_s1;
		entry_nx.fx    = ax.f;
		entry_nx.fy    = ay.f;
		if (entry_nx.is_wr) begin
			entry_nx.x0 = XW'(wx_s1);
			entry_nx.x1 = XW'(wx_s1);
			entry_nx.y0 = YW'(wy_s1);
			entry_nx.y1 = YW'(wy_s1);
		end else begin
			entry_nx.x0 = XW'(ax.p0);
			entry_nx.x1 = XW'(ax.p1);
			entry_nx.y0 = YW'(ay.p0);
			entry_nx.y1 = YW'(ay.p1);
		end
		case (mode_s1)
			bts_pkg::MODE_WRITE:    keep = wok_s1;
			bts_pkg::MODE_NEAREST:  keep = 1'b1;
			bts_pkg::MODE_BILINEAR: keep = 1'b1;
			default:                keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			entry_s2 <= entry_nx;
		end
	end

	assign push      = v_s2;
	assign push_data = entry_s2;

endmodule
`default_nettype wire

>>> rtl/core/bts_back.sv
// Sampler back: texel memory, four fetches per sample and the blend pipeline.
`default_nettype none
module bts_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int XW = 6,
	parameter int YW = 6,
	parameter int EW = 1 + bts_pkg::TEXW + 2*XW + 2*YW + 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [EW-1:0] head,
	input  wire logic          q_empty,
	output logic               pop,
	output logic               done,
	output logic [15:0]        out_red,
	output logic [15:0]        out_green,
	output logic [15:0]        out_blue
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CHW   = bts_pkg::CHW;
	localparam int NCH   = bts_pkg::NCH;

	typedef struct packed {
		logic                     is_wr;
		logic [bts_pkg::TEXW-1:0] data;
		logic [XW-1:0]            x0;
		logic [XW-1:0]            x1;
		logic [YW-1:0]            y0;
		logic [YW-1:0]            y1;
		logic [15:0]              fx;
		logic [15:0]              fy;
	} entry_t;

	entry_t h;
	logic [bts_pkg::TEXW-1:0] mem [DEPTH];
	logic [bts_pkg::TEXW-1:0] rdata_q;
	logic [1:0] phase_q;
	logic wr_en;
	logic rd_en;
	logic [XW-1:0] ax;
	logic [YW-1:0] ay;
	logic [AW-1:0] addr;

	logic v_s1;
	logic [1:0] ph_s1;
	logic [15:0] fx_s1;
	logic [15:0] fy_s1;
	logic [16:0] gx;

	logic v_s2;
	logic [1:0] ph_s2;
	logic [15:0] fy_s2;
	logic [31:0] m_s2 [NCH];
	logic [31:0] hold_q [NCH];

	logic v_s3;
	logic ph_s3;
	logic [15:0] fy_s3;
	logic [31:0] row_s3 [NCH];
	logic [31:0] row0_q [NCH];
	logic [16:0] gy;

	logic v_s4;
	logic [48:0] pa_s4 [NCH];
	logic [48:0] pb_s4 [NCH];
	logic [48:0] sum [NCH];
	logic [CHW-1:0] res_q [NCH];
	logic done_q;

	assign h = head;

	// Fetch sequencer: writes take one slot, samples four
	assign wr_en = !q_empty && h.is_wr;
	assign rd_en = !q_empty && !h.is_wr;
	assign pop   = wr_en || (rd_en && (phase_q == 2'd3));
	assign ax    = (rd_en && phase_q[0]) ? h.x1 : h.x0;
	assign ay    = (rd_en && phase_q[1]) ? h.y1 : h.y0;
	assign addr  = AW'(AW'(ay) * AW'(MAX_WIDTH)) + AW'(ax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			v_s1    <= 1'b0;
		end else begin
			if (rd_en) phase_q <= phase_q + 2'd1;
			v_s1 <= rd_en;
		end
	end

	// Single-port texel memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= h.data;
		end
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		ph_s1 <= phase_q;
		fx_s1 <= h.fx;
		fy_s1 <= h.fy;
	end

	// Horizontal weights on each fetched texel
	assign gx = 17'h10000 - {1'b0, fx_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2 && ph_s2[0];
			v_s4 <= v_s3 && ph_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ph_s2 <= ph_s1;
		fy_s2 <= fy_s1;
		for (int c = 0; c < NCH; c++) begin
			m_s2[c] <= 32'(rdata_q[c*CHW +: CHW] * (ph_s1[0] ? {1'b0, fx_s1} : gx));
		end
	end

	// Row sums: left texel held, right texel added
	always_ff @(posedge clk) begin
		ph_s3 <= ph_s2[1];
		fy_s3 <= fy_s2;
		for (int c = 0; c < NCH; c++) begin
			if (v_s2 && !ph_s2[0]) hold_q[c] <= m_s2[c];
			row_s3[c] <= hold_q[c] + m_s2[c];
		end
	end

	// Vertical weights on the two rows
	assign gy = 17'h10000 - {1'b0, fy_s3};

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			if (v_s3 && !ph_s3) row0_q[c] <= row_s3[c];
			pa_s4[c] <= 49'(row0_q[c] * gy);
			pb_s4[c] <= 49'(row_s3[c] * {1'b0, fy_s3});
		end
	end

	// Final sum, truncated to Q8.8
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			sum[c] = pa_s4[c] + pb_s4[c];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			res_q[c] <= sum[c][47:32];
		end
	end

	assign done      = done_q;
	assign out_blue  = res_q[0];
	assign out_green = res_q[1];
	assign out_red   = res_q[2];

endmodule
`default_nettype wire

>>> rtl/core/bilinear_texture_sampler_core.sv
// Top level of the bilinear texture sampler: register port, front, queue, back.
//
// Usage: drive a word on the input ports with start high; it is taken on
// the rising edge where start is high and busy is low. Mode write stores
// a texel (dropped outside tex_width x tex_height); modes nearest and
// bilinear each produce one result, shown on out_red/out_green/out_blue
// for exactly one cycle with done high. Results come in input order.
// Throughput: one write word per cycle while busy is low; the back starts
// the reads of a new sample only after the four texel reads of the last
// one are made through the single-port texel memory (nearest reads the
// same texel four times). A four-word command queue parts the front from
// the back; busy is high while the queue and the two front stages together
// hold four words. Results cannot be held off.
// Configuration: APB, registers at byte 0 tex_width, 4 tex_height,
// 8 wrap_s, 12 wrap_t; write them only while the block is idle.
// Reset: clears control state and sets 64x64, clamp on both axes; the
// texel memory is not cleared and must be written before it is sampled.
`default_nettype none
module bilinear_texture_sampler_core #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         mode,
	input  wire logic [5:0]         texel_x,
	input  wire logic [5:0]         texel_y,
	input  wire logic [15:0]        in_red,
	input  wire logic [15:0]        in_green,
	input  wire logic [15:0]        in_blue,
	input  wire logic signed [19:0] u_coord,
	input  wire logic signed [19:0] v_coord,
	output logic                    done,
	output logic      [15:0]        out_red,
	output logic      [15:0]        out_green,
	output logic      [15:0]        out_blue
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int EW = 1 + bts_pkg::TEXW + 2*XW + 2*YW + 32;

	logic [6:0] tex_width_q;
	logic [6:0] tex_height_q;
	logic wrap_s_q;
	logic wrap_t_q;
	logic cfg_wr;
	logic [1:0] reg_idx;
	bts_pkg::cfg_t cfg;

	logic push;
	logic [EW-1:0] push_data;
	logic pop;
	logic [EW-1:0] head;
	logic q_empty;
	logic [bts_pkg::QCW-1:0] q_count;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= bts_pkg::TEX_SIZE_RST;
			tex_height_q <= bts_pkg::TEX_SIZE_RST;
			wrap_s_q     <= 1'b1;
			wrap_t_q     <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				bts_pkg::REG_TEX_WIDTH:  tex_width_q  <= pwdata[6:0];
				bts_pkg::REG_TEX_HEIGHT: tex_height_q <= pwdata[6:0];
				bts_pkg::REG_WRAP_S:     wrap_s_q     <= pwdata[0];
				bts_pkg::REG_WRAP_T:     wrap_t_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bts_pkg::REG_TEX_WIDTH:  prdata = {25'd0, tex_width_q};
			bts_pkg::REG_TEX_HEIGHT: prdata = {25'd0, tex_height_q};
			bts_pkg::REG_WRAP_S:     prdata = {31'd0, wrap_s_q};
			bts_pkg::REG_WRAP_T:     prdata = {31'd0, wrap_t_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// Effective size: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (tex_width_q == 7'd0)
			cfg.width = 7'd1;
		else if (32'(tex_width_q) > MAX_WIDTH)
			cfg.width = 7'(MAX_WIDTH);
		else
			cfg.width = tex_width_q;
		if (tex_height_q == 7'd0)
			cfg.height = 7'd1;
		else if (32'(tex_height_q) > MAX_HEIGHT)
			cfg.height = 7'(MAX_HEIGHT);
		else
			cfg.height = tex_height_q;
		cfg.wrap_s = wrap_s_q;
		cfg.wrap_t = wrap_t_q;
	end

	bts_front #(.XW(XW), .YW(YW), .EW(EW)) u_front (
		.clk, .arst_n, .cfg, .start, .busy, .mode, .texel_x, .texel_y,
		.in_red, .in_green, .in_blue, .u_coord, .v_coord,
		.q_count, .push, .push_data
	);

	bts_queue #(.WIDTH(EW)) u_queue (
		.clk, .arst_n, .push, .push_data, .pop,
		.head, .empty(q_empty), .count(q_count)
	);

	bts_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.XW(XW), .YW(YW), .EW(EW)
	) u_back (
		.clk, .arst_n, .head, .q_empty, .pop,
		.done, .out_red, .out_green, .out_blue
	);

endmodule
`default_nettype wire
